>>> rtl/ffea_pkg.sv
// Shared types and constants for the first-fit extent allocator.
`timescale 1ns / 1ps
package ffea_pkg;

  localparam int MAX_EXTENTS  = 32;
  localparam int HEADER_BYTES = 8;
  localparam int ADDR_BITS    = 32;

  localparam int IDX_W     = $clog2(MAX_EXTENTS);
  localparam int CNT_W     = $clog2(MAX_EXTENTS + 1);
  localparam int LEN_W     = 32;
  localparam int DATA_W    = 32;
  localparam int ALIGN_W   = 8;
  localparam int ADJ_W     = 8;
  localparam int LG_W      = 3;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] POOL_BASE_RST = 32'd0;
  localparam logic [DATA_W-1:0] POOL_SIZE_RST = 32'd65536;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

>>> rtl/ffea_if.sv
// Handshake channel interfaces for request, result and configuration words.
`timescale 1ns / 1ps
interface ffea_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [ffea_pkg::DATA_W-1:0]   request_size;
  logic [ffea_pkg::ALIGN_W-1:0]  alignment;
  logic [ffea_pkg::DATA_W-1:0]   freed_address;
  logic [ffea_pkg::DATA_W-1:0]   freed_total_size;
  logic [ffea_pkg::ADJ_W-1:0]    freed_adjustment;
  modport source (output valid, command, request_size, alignment, freed_address,
                  freed_total_size, freed_adjustment, input ready);
  modport sink (input valid, command, request_size, alignment, freed_address,
                freed_total_size, freed_adjustment, output ready);
endinterface

interface ffea_out_if;
  logic                         valid;
  logic                         ready;
  logic [ffea_pkg::ST_W-1:0]    status;
  logic [ffea_pkg::DATA_W-1:0]  granted_address;
  logic [ffea_pkg::DATA_W-1:0]  granted_total_size;
  logic [ffea_pkg::ADJ_W-1:0]   granted_adjustment;
  logic [ffea_pkg::DATA_W-1:0]  used_bytes;
  logic [ffea_pkg::DATA_W-1:0]  allocation_count;
  modport source (output valid, status, granted_address, granted_total_size,
                  granted_adjustment, used_bytes, allocation_count, input ready);
  modport sink (input valid, status, granted_address, granted_total_size,
                granted_adjustment, used_bytes, allocation_count, output ready);
endinterface

interface ffea_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ffea_pkg::CFG_IDX_W-1:0] index;
  logic [ffea_pkg::DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ffea_ctrl.sv
// Controller state machine: accept, table scan, table update and result hand-off.
`timescale 1ns / 1ps
module ffea_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ffea_pkg::dp_sts_t  sts,
  output ffea_pkg::ctl_cmd_t cmd
);
  import ffea_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_APPLY: begin
        // The table update waits until the output register can take the word.
        if (slot_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.apply ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/ffea_datapath.sv
// Datapath: extent table, request registers, fit and merge logic, result register.
`timescale 1ns / 1ps
module ffea_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffea_pkg::ctl_cmd_t            cmd,
  output ffea_pkg::dp_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [ffea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffea_pkg::DATA_W-1:0]   cfg_data,
  input  logic                          in_command,
  input  logic [ffea_pkg::DATA_W-1:0]   in_request_size,
  input  logic [ffea_pkg::ALIGN_W-1:0]  in_alignment,
  input  logic [ffea_pkg::DATA_W-1:0]   in_freed_address,
  input  logic [ffea_pkg::DATA_W-1:0]   in_freed_total_size,
  input  logic [ffea_pkg::ADJ_W-1:0]    in_freed_adjustment,
  output logic [ffea_pkg::ST_W-1:0]     out_status,
  output logic [ffea_pkg::DATA_W-1:0]   out_granted_address,
  output logic [ffea_pkg::DATA_W-1:0]   out_granted_total_size,
  output logic [ffea_pkg::ADJ_W-1:0]    out_granted_adjustment,
  output logic [ffea_pkg::DATA_W-1:0]   out_used_bytes,
  output logic [ffea_pkg::DATA_W-1:0]   out_allocation_count
);
  import ffea_pkg::*;

  // Free extent table, address sorted.
  logic [ADDR_BITS-1:0] start_r [MAX_EXTENTS];
  logic [ADDR_BITS-1:0] start_nxt [MAX_EXTENTS];
  logic [LEN_W-1:0]     len_r [MAX_EXTENTS];
  logic [LEN_W-1:0]     len_nxt [MAX_EXTENTS];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [DATA_W-1:0] base_r, base_nxt, size_r, size_nxt;
  logic [DATA_W-1:0] bytes_r, bytes_nxt, live_r, live_nxt;

  // Request held for the scan.
  logic                 cmd_r;
  logic [DATA_W-1:0]    req_size_r;
  logic [LG_W-1:0]      lg_r, lg_in;
  logic [ADDR_BITS-1:0] bs_r;
  logic [LEN_W-1:0]     sz_r;
  logic [ADDR_BITS:0]   be_r;
  logic [CNT_W-1:0]     idx_r;
  logic                 have_prev_r;
  logic [ADDR_BITS:0]   prev_end_r;
  logic [LEN_W-1:0]     prev_len_r;

  logic [ST_W-1:0]   st_r, st_nxt;
  logic [DATA_W-1:0] ga_r, ga_nxt, gs_r, gs_nxt;
  logic [ADJ_W-1:0]  gj_r, gj_nxt;

  logic [IDX_W-1:0]     ridx, pidx;
  logic [ADDR_BITS-1:0] cur_s;
  logic [LEN_W-1:0]     cur_l;
  logic                 at_end;
  logic [ADJ_W-1:0]     amask, mis, adj;
  logic [ADJ_W:0]       need9, kk9, adj9;
  logic [DATA_W:0]      total;
  logic                 fits, absorb, mprev, mnext;
  logic [LEN_W-1:0]     left;
  logic [ADDR_BITS-1:0] bs_in;

  assign ridx   = idx_r[IDX_W-1:0];
  assign pidx   = ridx - IDX_W'(1);
  assign cur_s  = start_r[ridx];
  assign cur_l  = len_r[ridx];
  assign at_end = idx_r >= cnt_r;

  // Alignment rounded down to a power of two; zero counts as one.
  always_comb begin
    lg_in = '0;
    for (int b = 0; b < ALIGN_W; b++) begin
      if (in_alignment[b]) lg_in = LG_W'(b);
    end
  end

  // Header-aware adjustment for the extent under the scan pointer.
  always_comb begin
    amask = (ADJ_W'(1) << lg_r) - ADJ_W'(1);
    mis   = (~cur_s[ADJ_W-1:0] + ADJ_W'(1)) & amask;
    need9 = '0;
    kk9   = '0;
    adj9  = {1'b0, mis};
    if (mis < ADJ_W'(HEADER_BYTES)) begin
      need9 = (ADJ_W+1)'(HEADER_BYTES) - {1'b0, mis};
      kk9   = ((need9 + {1'b0, amask}) >> lg_r) << lg_r;
      adj9  = {1'b0, mis} + kk9;
    end
    adj = adj9[ADJ_W-1:0];
  end

  assign total  = {1'b0, req_size_r} + (DATA_W+1)'(adj);
  assign fits   = {1'b0, cur_l} >= total;
  assign left   = cur_l - total[LEN_W-1:0];
  assign absorb = left <= LEN_W'(HEADER_BYTES);
  assign mprev  = have_prev_r && (prev_end_r == {1'b0, bs_r});
  assign mnext  = !at_end && ({1'b0, cur_s} == be_r);

  always_comb begin
    if (cmd_r == CMD_ALLOC) begin
      sts.scan_done = at_end || fits;
    end else begin
      sts.scan_done = at_end || ({1'b0, cur_s} >= be_r);
    end
  end

  assign bs_in = ADDR_BITS'(in_freed_address - DATA_W'(in_freed_adjustment));

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    size_nxt  = size_r;
    bytes_nxt = bytes_r;
    live_nxt  = live_r;
    st_nxt    = st_r;
    ga_nxt    = ga_r;
    gs_nxt    = gs_r;
    gj_nxt    = gj_r;
    if (cfg_we) begin
      if (cfg_index == REG_POOL_BASE) begin
        base_nxt = cfg_data;
      end else begin
        size_nxt = cfg_data;
      end
      start_nxt[0] = ADDR_BITS'(base_nxt);
      len_nxt[0]   = size_nxt;
      cnt_nxt      = (size_nxt != '0) ? CNT_W'(1) : '0;
      bytes_nxt    = '0;
      live_nxt     = '0;
    end else if (cmd.apply) begin
      st_nxt = ST_OK;
      ga_nxt = '0;
      gs_nxt = '0;
      gj_nxt = '0;
      if (cmd_r == CMD_ALLOC) begin
        if (at_end) begin
          st_nxt = ST_NOFIT;
        end else begin
          ga_nxt = DATA_W'(cur_s + ADDR_BITS'(adj));
          gj_nxt = adj;
          if (absorb) begin
            gs_nxt = cur_l;
            for (int j = 0; j < MAX_EXTENTS; j++) begin
              if (j >= int'(ridx)) begin
                start_nxt[j] = (j < MAX_EXTENTS - 1) ? start_r[(j+1) % MAX_EXTENTS] : '0;
                len_nxt[j]   = (j < MAX_EXTENTS - 1) ? len_r[(j+1) % MAX_EXTENTS] : '0;
              end
            end
            cnt_nxt = cnt_r - CNT_W'(1);
          end else begin
            gs_nxt          = total[DATA_W-1:0];
            start_nxt[ridx] = cur_s + ADDR_BITS'(total[LEN_W-1:0]);
            len_nxt[ridx]   = left;
          end
          bytes_nxt = bytes_r + gs_nxt;
          live_nxt  = live_r + DATA_W'(1);
        end
      end else begin
        if (mprev) begin
          len_nxt[pidx] = prev_len_r + sz_r + (mnext ? cur_l : '0);
          if (mnext) begin
            for (int j = 0; j < MAX_EXTENTS; j++) begin
              if (j >= int'(ridx)) begin
                start_nxt[j] = (j < MAX_EXTENTS - 1) ? start_r[(j+1) % MAX_EXTENTS] : '0;
                len_nxt[j]   = (j < MAX_EXTENTS - 1) ? len_r[(j+1) % MAX_EXTENTS] : '0;
              end
            end
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end else if (mnext) begin
          start_nxt[ridx] = bs_r;
          len_nxt[ridx]   = cur_l + sz_r;
        end else if (cnt_r >= CNT_W'(MAX_EXTENTS)) begin
          st_nxt = ST_FULL;
        end else begin
          for (int j = 0; j < MAX_EXTENTS; j++) begin
            if (j > int'(ridx)) begin
              start_nxt[j] = start_r[(j+MAX_EXTENTS-1) % MAX_EXTENTS];
              len_nxt[j]   = len_r[(j+MAX_EXTENTS-1) % MAX_EXTENTS];
            end
          end
          start_nxt[ridx] = bs_r;
          len_nxt[ridx]   = sz_r;
          cnt_nxt         = cnt_r + CNT_W'(1);
        end
        if (st_nxt == ST_OK) begin
          bytes_nxt = bytes_r - sz_r;
          live_nxt  = live_r - DATA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_EXTENTS; j++) begin
        start_r[j] <= (j == 0) ? ADDR_BITS'(POOL_BASE_RST) : '0;
        len_r[j]   <= (j == 0) ? POOL_SIZE_RST : '0;
      end
      cnt_r      <= CNT_W'(1);
      base_r     <= POOL_BASE_RST;
      size_r     <= POOL_SIZE_RST;
      bytes_r    <= '0;
      live_r     <= '0;
      idx_r      <= '0;
      cmd_r      <= CMD_ALLOC;
      have_prev_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      size_r  <= size_nxt;
      bytes_r <= bytes_nxt;
      live_r  <= live_nxt;
      if (cmd.load) begin
        idx_r       <= '0;
        cmd_r       <= in_command;
        have_prev_r <= 1'b0;
      end else if (cmd.step) begin
        idx_r       <= idx_r + CNT_W'(1);
        have_prev_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    ga_r <= ga_nxt;
    gs_r <= gs_nxt;
    gj_r <= gj_nxt;
    if (cmd.load) begin
      req_size_r <= in_request_size;
      lg_r       <= lg_in;
      bs_r       <= bs_in;
      sz_r       <= in_freed_total_size;
      be_r       <= {1'b0, bs_in} + (ADDR_BITS+1)'(in_freed_total_size);
    end
    if (cmd.step) begin
      prev_end_r <= {1'b0, cur_s} + (ADDR_BITS+1)'(cur_l);
      prev_len_r <= cur_l;
    end
  end

  assign out_status             = st_r;
  assign out_granted_address    = ga_r;
  assign out_granted_total_size = gs_r;
  assign out_granted_adjustment = gj_r;
  assign out_used_bytes         = bytes_r;
  assign out_allocation_count   = live_r;

endmodule

>>> rtl/first_fit_extent_allocator.sv
// Per word: load, a table scan of k entries (0 to MAX_EXTENTS) at one entry a cycle, then the update
// that registers the result, which waits until the output register is free to take it.
// A new word is taken while the previous result still waits in the output register.
// Reset (rst_n low at a clock edge): one extent covering the default pool, counters zero.
// Writing pool_base or pool_size rebuilds the table the same way.
`timescale 1ns / 1ps
module first_fit_extent_allocator (
  input logic         clk,
  input logic         rst_n,
  ffea_in_if.sink     in_ch,
  ffea_out_if.source  out_ch,
  ffea_cfg_if.sink    cfg_ch
);
  import ffea_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Config words are taken at any time; the user must send them only while the block is idle.
  assign cfg_ch.ready = 1'b1;

  // The controller sequences accept, scan and update; the datapath holds the table.
  ffea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffea_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_ch.valid),
    .cfg_index              (cfg_ch.index),
    .cfg_data               (cfg_ch.data),
    .in_command             (in_ch.command),
    .in_request_size        (in_ch.request_size),
    .in_alignment           (in_ch.alignment),
    .in_freed_address       (in_ch.freed_address),
    .in_freed_total_size    (in_ch.freed_total_size),
    .in_freed_adjustment    (in_ch.freed_adjustment),
    .out_status             (out_ch.status),
    .out_granted_address    (out_ch.granted_address),
    .out_granted_total_size (out_ch.granted_total_size),
    .out_granted_adjustment (out_ch.granted_adjustment),
    .out_used_bytes         (out_ch.used_bytes),
    .out_allocation_count   (out_ch.allocation_count)
  );

endmodule

>>> rtl/ffea_checker.sv
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
module ffea_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ffea_pkg::ST_W-1:0]    status,
  input logic [ffea_pkg::DATA_W-1:0]  granted_address,
  input logic [ffea_pkg::DATA_W-1:0]  granted_total_size,
  input logic [ffea_pkg::ADJ_W-1:0]   granted_adjustment
);
  import ffea_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |->
      granted_address == '0 && granted_total_size == '0 && granted_adjustment == '0)
    else $error("failed request carries a grant");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while a request is in work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .status             (out_ch.status),
  .granted_address    (out_ch.granted_address),
  .granted_total_size (out_ch.granted_total_size),
  .granted_adjustment (out_ch.granted_adjustment)
);
